FILE: rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, codes and helpers for the LRU page cache.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int CFG_W = 5;
    localparam int CTR_W = 32;

    localparam logic [1:0] OP_LOOKUP     = 2'd0;
    localparam logic [1:0] OP_INSERT     = 2'd1;
    localparam logic [1:0] OP_INVALIDATE = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } lpc_state_t;

    // what every cell does in the update cycle
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_TOUCH,
        CMD_DROP,
        CMD_INSERT,
        CMD_INSERT_EVICT
    } cmd_kind_t;

    typedef struct packed {
        logic      apply;
        cmd_kind_t kind;
    } cell_cmd_t;

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
        sat_inc = (v == {CTR_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

FILE: rtl/lpc_cell.sv
// ----------------------------------------------------------------------------
// lpc_cell
// One tag slot: valid bit, page tag and recency rank (0 = most recent).
// Passes the first-free search on to its neighbour.
// ----------------------------------------------------------------------------
module lpc_cell
    import lpc_pkg::*;
#(
    parameter int PAGE_BITS = 52,
    parameter int RANK_W    = 4,
    parameter int CNT_W     = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  logic [PAGE_BITS-1:0] page_in,
    input  logic [RANK_W-1:0]    ref_rank,
    input  logic [CNT_W-1:0]     count,
    input  logic                 free_in,
    output logic                 free_out,
    output logic                 match,
    output logic                 lru,
    output logic [RANK_W-1:0]    rank,
    output logic [PAGE_BITS-1:0] page_out
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [RANK_W-1:0]    rank_reg;
    logic [RANK_W-1:0]    rank_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 page_wr;
    logic                 free_here;
    logic                 take;

    assign match    = valid_reg && (page_reg == page_in);
    // oldest valid entry holds rank count-1
    assign lru      = valid_reg && (rank_reg == RANK_W'(count - 1'b1));
    assign rank     = rank_reg;
    assign page_out = page_reg;

    assign free_here = !valid_reg || ((cmd.kind == CMD_INSERT_EVICT) && lru);
    assign take      = free_in && free_here;
    assign free_out  = free_in && !free_here;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        page_wr    = 1'b0;
        if (cmd.apply)
        begin
            case (cmd.kind) inside
                CMD_TOUCH:
                begin
                    if (match)
                        rank_next = '0;
                    else if (valid_reg && (rank_reg < ref_rank))
                        rank_next = rank_reg + 1'b1;
                end
                CMD_DROP:
                begin
                    if (match)
                    begin
                        valid_next = 1'b0;
                        rank_next  = '0;
                    end
                    else if (valid_reg && (rank_reg > ref_rank))
                        rank_next = rank_reg - 1'b1;
                end
                CMD_INSERT, CMD_INSERT_EVICT:
                begin
                    if (take)
                    begin
                        valid_next = 1'b1;
                        rank_next  = '0;
                        page_wr    = 1'b1;
                    end
                    else if ((cmd.kind == CMD_INSERT_EVICT) && lru)
                    begin
                        valid_next = 1'b0;
                        rank_next  = '0;
                    end
                    else if (valid_reg)
                        rank_next = rank_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (page_wr)
            page_reg <= page_in;
    end

endmodule

FILE: rtl/lru_page_cache.sv
// ----------------------------------------------------------------------------
// lru_page_cache
// Fully associative page-tag store in LRU order, built as a row of tag cells.
//
//   channel | dir | handshake          | content
//   s_*     | in  | s_tvalid/s_tready  | opcode, page
//   m_*     | out | m_tvalid/m_tready  | found, evicted, victim_page, counters
//   cfg_*   | in  | cfg_valid/cfg_ready| entries_enabled
//
// Each request passes through capture, a search cycle in which every cell
// compares its tag and the hit rank and LRU tag are registered, and an update
// cycle in which all cells shift ranks and the result is loaded.
// The update waits while the output register still holds an untaken result.
// Reset empties all cells, clears the counters and sets entries_enabled to 16.
// ----------------------------------------------------------------------------
module lru_page_cache
    import lpc_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int PAGE_BITS = 52
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // [1:0] opcode, [PAGE_BITS+1:2] page, zero pad
    input  logic [((2+PAGE_BITS+7)/8)*8-1:0]              s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // [0] found, [1] evicted, victim_page, hit_total, miss_total,
    // eviction_total, zero pad
    output logic [((2+PAGE_BITS+3*CTR_W+7)/8)*8-1:0]      m_tdata,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [CFG_W-1:0]                              cfg_data
);

    localparam int OUT_W  = ((2 + PAGE_BITS + 3*CTR_W + 7) / 8) * 8;
    localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    lpc_state_t           state_reg;
    lpc_state_t           state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [1:0]           op_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    cmd_kind_t            kind_reg;
    cmd_kind_t            kind_next;
    logic                 found_reg;
    logic                 found_next;
    logic                 evicted_reg;
    logic                 evicted_next;
    logic [PAGE_BITS-1:0] victim_reg;
    logic [PAGE_BITS-1:0] victim_next;
    logic [RANK_W-1:0]    hit_rank_reg;
    logic                 hit_inc_reg;
    logic                 hit_inc_next;
    logic                 miss_inc_reg;
    logic                 miss_inc_next;

    logic [CTR_W-1:0]     hit_cnt_reg;
    logic [CTR_W-1:0]     hit_cnt_next;
    logic [CTR_W-1:0]     miss_cnt_reg;
    logic [CTR_W-1:0]     miss_cnt_next;
    logic [CTR_W-1:0]     evict_cnt_reg;
    logic [CTR_W-1:0]     evict_cnt_next;

    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;
    logic [OUT_W-1:0]     m_data_next;

    logic                 advance;
    cell_cmd_t            cmd;
    logic [LIM_W-1:0]     limit;

    logic [CAPACITY:0]    free_chain;
    logic [CAPACITY-1:0]  match;
    logic [CAPACITY-1:0]  lru;
    logic [RANK_W-1:0]    rank     [CAPACITY];
    logic [PAGE_BITS-1:0] page_out [CAPACITY];

    logic                 hit_any;
    logic [RANK_W-1:0]    hit_rank;
    logic [PAGE_BITS-1:0] lru_page;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign advance    = (state_reg == ST_UPDATE) && (!m_valid_reg || m_tready);
    assign cmd.apply  = advance;
    assign cmd.kind   = kind_reg;
    assign free_chain[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            lpc_cell #(
                .PAGE_BITS (PAGE_BITS),
                .RANK_W    (RANK_W),
                .CNT_W     (CNT_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .page_in  (page_reg),
                .ref_rank (hit_rank_reg),
                .count    (count_reg),
                .free_in  (free_chain[g]),
                .free_out (free_chain[g+1]),
                .match    (match[g]),
                .lru      (lru[g]),
                .rank     (rank[g]),
                .page_out (page_out[g])
            );
        end
    endgenerate

    // at most one cell matches and at most one is LRU, so OR-merge works
    always_comb
    begin
        hit_any  = 1'b0;
        hit_rank = '0;
        lru_page = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_any  = hit_any | match[i];
            hit_rank = hit_rank | (match[i] ? rank[i] : '0);
            lru_page = lru_page | (lru[i] ? page_out[i] : '0);
        end
    end

    assign limit = (LIM_W'(cfg_reg) > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY)
                                                          : LIM_W'(cfg_reg);

    // search-cycle decision
    always_comb
    begin
        kind_next     = CMD_NONE;
        found_next    = 1'b0;
        evicted_next  = 1'b0;
        victim_next   = '0;
        hit_inc_next  = 1'b0;
        miss_inc_next = 1'b0;
        case (op_reg)
            OP_LOOKUP:
            begin
                if ((limit != '0) && hit_any)
                begin
                    kind_next    = CMD_TOUCH;
                    found_next   = 1'b1;
                    hit_inc_next = 1'b1;
                end
                else
                    miss_inc_next = 1'b1;
            end
            OP_INSERT:
            begin
                if (limit != '0)
                begin
                    if (hit_any)
                    begin
                        kind_next  = CMD_TOUCH;
                        found_next = 1'b1;
                    end
                    else if (LIM_W'(count_reg) >= limit)
                    begin
                        kind_next    = CMD_INSERT_EVICT;
                        evicted_next = 1'b1;
                        victim_next  = lru_page;
                    end
                    else
                        kind_next = CMD_INSERT;
                end
            end
            OP_INVALIDATE:
            begin
                if (hit_any)
                begin
                    kind_next  = CMD_DROP;
                    found_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        case (kind_reg)
            CMD_INSERT: count_next = count_reg + 1'b1;
            CMD_DROP:   count_next = count_reg - 1'b1;
            default:    count_next = count_reg;
        endcase
    end

    assign hit_cnt_next   = hit_inc_reg  ? sat_inc(hit_cnt_reg)   : hit_cnt_reg;
    assign miss_cnt_next  = miss_inc_reg ? sat_inc(miss_cnt_reg)  : miss_cnt_reg;
    assign evict_cnt_next = evicted_reg  ? sat_inc(evict_cnt_reg) : evict_cnt_reg;

    assign m_data_next = OUT_W'({evict_cnt_next, miss_cnt_next, hit_cnt_next,
                                 victim_reg, evicted_reg, found_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_SEARCH;
            ST_SEARCH:
                state_next = ST_UPDATE;
            ST_UPDATE:
                if (advance)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= CFG_RESET;
            count_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
            kind_reg      <= CMD_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                cfg_reg <= cfg_data;
            if (state_reg == ST_SEARCH)
                kind_reg <= kind_next;
            if (advance)
            begin
                count_reg     <= count_next;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                m_valid_reg   <= 1'b1;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tdata[1:0];
            page_reg <= s_tdata[2 +: PAGE_BITS];
        end
        if (state_reg == ST_SEARCH)
        begin
            found_reg    <= found_next;
            evicted_reg  <= evicted_next;
            victim_reg   <= victim_next;
            hit_rank_reg <= hit_rank;
            hit_inc_reg  <= hit_inc_next;
            miss_inc_reg <= miss_inc_next;
        end
        if (advance)
            m_data_reg <= m_data_next;
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for lru_page_cache. Requests are driven on the s_ stream
// and the reply for each request is predicted by an LRU tag store held in the
// bench. Every reply taken from the m_ stream is checked field by field
// against the oldest prediction. A directed sequence comes first and covers
// eviction, disabled caching, the unused opcode and an oversized limit. Random
// segments follow, each writing its own entries_enabled, and the idle patterns
// on either side change between groups of segments.
// ----------------------------------------------------------------------------
module tb_top;
    import lpc_pkg::*;

    localparam int PAGE_W  = 52;
    localparam int S_W     = 56;
    localparam int M_W     = 152;
    localparam int SLOTS   = 16;
    localparam int POOL_N  = 20;
    localparam int SEGS    = 13;
    localparam int SEG_LEN = 100;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};

    typedef struct packed {
        logic              found;
        logic              evicted;
        logic [PAGE_W-1:0] victim;
        logic [CTR_W-1:0]  hits;
        logic [CTR_W-1:0]  misses;
        logic [CTR_W-1:0]  evictions;
    } page_reply_t;

    class page_cache_model;
        bit                valid [SLOTS];
        logic [PAGE_W-1:0] tag [SLOTS];
        int unsigned       rank [SLOTS];
        logic [CTR_W-1:0]  hits;
        logic [CTR_W-1:0]  misses;
        logic [CTR_W-1:0]  evictions;
        int unsigned       limit;
        page_reply_t       pending_replies [$];
        int                errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                valid[i] = 0;
                rank[i]  = 0;
            end
            hits      = '0;
            misses    = '0;
            evictions = '0;
            limit     = 32'(CFG_RESET);
            errors    = 0;
        endfunction

        function void set_limit(input logic [CFG_W-1:0] v);
            limit = 32'(v);
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function logic [CTR_W-1:0] bump(input logic [CTR_W-1:0] v);
            return (v == {CTR_W{1'b1}}) ? v : v + 1'b1;
        endfunction

        function void touch(input int k);
            for (int i = 0; i < SLOTS; i++)
                if (valid[i] && rank[i] < rank[k])
                    rank[i]++;
            rank[k] = 0;
        endfunction

        function void drop(input int k);
            for (int i = 0; i < SLOTS; i++)
                if (valid[i] && rank[i] > rank[k])
                    rank[i]--;
            valid[k] = 0;
            rank[k]  = 0;
        endfunction

        function void note_request(input logic [1:0] op, input logic [PAGE_W-1:0] page);
            int          k;
            int          n;
            int          lru;
            int          slot;
            int unsigned lim;
            page_reply_t r;
            k    = -1;
            n    = 0;
            lru  = -1;
            slot = -1;
            r    = '0;
            lim  = (limit > SLOTS) ? SLOTS : limit;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (valid[i] && tag[i] == page)
                    k = i;
            case (op)
                OP_LOOKUP:
                begin
                    if (lim != 0 && k >= 0)
                    begin
                        r.found = 1'b1;
                        touch(k);
                        hits = bump(hits);
                    end
                    else
                        misses = bump(misses);
                end
                OP_INSERT:
                begin
                    if (lim != 0 && k >= 0)
                    begin
                        r.found = 1'b1;
                        touch(k);
                    end
                    else if (lim != 0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (valid[i])
                                n++;
                        // full (or over a lowered limit): only one victim per request
                        if (n >= lim)
                        begin
                            for (int i = 0; i < SLOTS; i++)
                                if (valid[i] && (lru < 0 || rank[i] > rank[lru]))
                                    lru = i;
                            if (lru >= 0)
                            begin
                                r.evicted = 1'b1;
                                r.victim  = tag[lru];
                                drop(lru);
                                evictions = bump(evictions);
                            end
                        end
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!valid[i])
                                slot = i;
                        if (slot >= 0)
                        begin
                            for (int i = 0; i < SLOTS; i++)
                                if (valid[i])
                                    rank[i]++;
                            valid[slot] = 1;
                            tag[slot]   = page;
                            rank[slot]  = 0;
                        end
                    end
                end
                OP_INVALIDATE:
                begin
                    if (k >= 0)
                    begin
                        r.found = 1'b1;
                        drop(k);
                    end
                end
                default: ;
            endcase
            r.hits      = hits;
            r.misses    = misses;
            r.evictions = evictions;
            pending_replies.push_back(r);
        endfunction

        function void compare(input string name, input logic [63:0] want,
                              input logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_reply(input logic [M_W-1:0] d);
            page_reply_t want;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none, actual %0h", $time, d);
                return;
            end
            want = pending_replies.pop_front();
            compare("found", 64'(want.found), 64'(d[0]));
            compare("evicted", 64'(want.evicted), 64'(d[1]));
            compare("victim_page", 64'(want.victim), 64'(d[53:2]));
            compare("hit_total", 64'(want.hits), 64'(d[85:54]));
            compare("miss_total", 64'(want.misses), 64'(d[117:86]));
            compare("eviction_total", 64'(want.evictions), 64'(d[149:118]));
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    page_cache_model  model = new();
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    logic             stall_trigger = 1'b0;
    bit               stall_taken   = 0;
    int               stall_cycles  = 0;
    logic [PAGE_W-1:0] page_pool [POOL_N];

    always #10 clk = ~clk;

    lru_page_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // reply side: checks taken replies, throttles m_tready, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                model.check_reply(m_tdata);
            if (stall_trigger && !stall_taken)
            begin
                stall_taken  = 1;
                stall_cycles = 80;
            end
            if (stall_cycles > 0)
            begin
                stall_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [PAGE_W-1:0] page);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {2'b00, page, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model.note_request(op, page);
    endtask

    task automatic drain();
        while (model.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model.set_limit(v);
    endtask

    function automatic logic [PAGE_W-1:0] any_page();
        return PAGE_W'({$urandom, $urandom});
    endfunction

    initial
    begin
        logic [CFG_W-1:0] seg_limit [SEGS];
        logic [PAGE_W-1:0] pa;
        logic [PAGE_W-1:0] pb;
        logic [1:0]        op;
        logic [PAGE_W-1:0] page;
        int                done;
        int                r;
        seg_limit = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd12, 5'd17, 5'd5,
                      5'd31, 5'd2, 5'd16, 5'd7, 5'd4};
        for (int i = 0; i < POOL_N; i++)
            page_pool[i] = any_page();
        pa = page_pool[0];
        pb = page_pool[1];

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two entries: LRU victim, refresh on hit, double invalidate, unused opcode
        write_limit(5'd2);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, PAGE_MAX);
        send_request(OP_LOOKUP, '0);
        send_request(OP_INSERT, pa);
        send_request(OP_LOOKUP, PAGE_MAX);
        send_request(OP_INSERT, '0);
        send_request(OP_INVALIDATE, pa);
        send_request(OP_INVALIDATE, pa);
        send_request(OP_UNUSED, PAGE_MAX);
        send_request(OP_LOOKUP, pa);
        // caching off: lookups miss, inserts do nothing, invalidate still acts
        write_limit(5'd0);
        send_request(OP_LOOKUP, '0);
        send_request(OP_INSERT, pa);
        send_request(OP_INVALIDATE, '0);
        write_limit(5'd1);
        send_request(OP_INSERT, pa);
        send_request(OP_INSERT, pb);
        send_request(OP_LOOKUP, pb);
        // limit beyond capacity behaves as full capacity
        write_limit(5'd31);
        send_request(OP_INSERT, pa);
        send_request(OP_LOOKUP, pa);

        for (int s = 0; s < SEGS; s++)
        begin
            write_limit(seg_limit[s]);
            if (s < 4)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 79;
            end
            else if (s < 8)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // back-pressure: replies held off while requests keep coming
            if (s == 8)
                stall_trigger <= 1'b1;
            done = 0;
            while (done < SEG_LEN)
            begin
                if (s == 10 && done == SEG_LEN / 2)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    drain();
                end
                r = $urandom_range(99);
                if (r < 40)
                    op = OP_LOOKUP;
                else if (r < 75)
                    op = OP_INSERT;
                else if (r < 92)
                    op = OP_INVALIDATE;
                else
                    op = OP_UNUSED;
                if ($urandom_range(99) < 85)
                    page = page_pool[$urandom_range(POOL_N - 1)];
                else
                    page = any_page();
                send_request(op, page);
                done++;
            end
        end

        s_tvalid <= 1'b0;
        drain();
        repeat (10) @(posedge clk);
        if (model.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule
